>>> design/opsi_pkg.sv
// Shared types, widths and tables for the object path smoothing interpolator.
// No dependencies; every other design file refers to this package by scope.
package opsi_pkg;

  localparam int POS_FRAC_BITS     = 24;
  localparam int MAX_SMOOTH_POINTS = 80;
  localparam int MAX_SUB_BLOCKS    = 16;

  localparam int POS_W  = POS_FRAC_BITS + 1;  // position field width
  localparam int STEP_W = POS_W + 1;          // signed per-point step
  localparam int DIV_W  = POS_W + 2;          // holds the sum of three |delta|
  localparam int DEN_W  = 7;                  // sub-block count or run length - 1
  localparam int IDX_W  = 7;                  // point index and run length
  localparam int SBC_W  = 5;
  localparam int LVL_W  = 2;
  localparam int FR_W   = 8;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_3   = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
    logic [POS_W-1:0] start_z;
    logic [POS_W-1:0] end_x;
    logic [POS_W-1:0] end_y;
    logic [POS_W-1:0] end_z;
    logic [SBC_W-1:0] sub_block_count;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [IDX_W-1:0] point_index;
    logic [IDX_W-1:0] run_length;
    logic [LVL_W-1:0] speed_level;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [FR_W-1:0]  frame_rate;
    logic             adaptive_speed;
    logic [POS_W-1:0] thresh_one;
    logic [POS_W-1:0] thresh_two;
    logic [POS_W-1:0] thresh_three;
  } cfg_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic load;       // capture endpoints and |delta|
    logic adv;        // step: add offset
    logic force_end;  // step: snap to end position
    logic div_start;  // start the offset divide
  } lane_ctl_t;

  // run length table, rows by frame rate, columns by speed level
  localparam logic [IDX_W-1:0] RUN_TABLE [3][4] = '{
    '{7'd8, 7'd16, 7'd40, 7'd80},
    '{7'd4, 7'd8,  7'd20, 7'd40},
    '{7'd2, 7'd4,  7'd10, 7'd20}
  };

  function automatic logic [1:0] rate_row(input logic [FR_W-1:0] fr);
    logic [1:0] row;
    if (fr == 8'd48 || fr == 8'd50 || fr == 8'd60) row = 2'd1;
    else if (fr == 8'd96 || fr == 8'd100 || fr == 8'd120) row = 2'd2;
    else row = 2'd0;
    return row;
  endfunction

  function automatic logic [IDX_W-1:0] run_len(input logic [1:0] row,
                                               input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] n;
    n = RUN_TABLE[row][lvl];
    if (n > IDX_W'(MAX_SMOOTH_POINTS)) n = IDX_W'(MAX_SMOOTH_POINTS);
    if (n < IDX_W'(2)) n = IDX_W'(2);
    return n;
  endfunction

endpackage

>>> design/object_path_smoothing_interpolator.sv
// Top level of the object path smoothing interpolator: sequencer, counters,
// configuration registers and output register. Uses opsi_pkg, opsi_lane, opsi_speed.
//
// A load transaction (cmd = 0) posts point 0 after these steps in order: the
// speed stage starts; the serial divide of the summed |delta| by the sub-block
// count loads its operands and forms a 27-bit quotient bit by bit; the speed
// level is classified and the run length looked up and handed off to the
// lanes; the serial divide in each of the three axis lanes (run in parallel)
// forms the per-point offset; the result is posted. A step transaction
// (cmd = 1) yields its point in the cycle after it is accepted, and while no
// load is in progress a new step is taken every cycle the output register is
// free or being emptied, so steps sustain one per cycle when the receiver
// never stalls. Inputs are taken only while the sequencer is idle and the
// output register can take a result. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while no load is in
// progress.
module object_path_smoothing_interpolator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  opsi_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output opsi_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [opsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [opsi_pkg::POS_W-1:0]       cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SPD_START = 6'b000010,
    ST_SPD_WAIT  = 6'b000100,
    ST_DIV_START = 6'b001000,
    ST_DIV_WAIT  = 6'b010000,
    ST_EMIT      = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  opsi_pkg::cfg_t               cfg_r;
  logic [opsi_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [opsi_pkg::IDX_W-1:0]   total_r;
  logic [opsi_pkg::LVL_W-1:0]   level_r;
  logic                         out_valid_r;
  opsi_pkg::out_item_t          out_data_r;

  logic                         out_free;
  logic                         in_acc, load_acc, step_acc;
  logic [opsi_pkg::IDX_W:0]     cnt_inc, tot_ext;
  logic                         force_end;
  opsi_pkg::lane_ctl_t          lane_ctl;
  logic [opsi_pkg::DEN_W-1:0]   div_den;
  logic [opsi_pkg::POS_W-1:0]   abs_d [3];
  logic [opsi_pkg::POS_W-1:0]   cur_p [3];
  logic [opsi_pkg::POS_W-1:0]   nxt_p [3];
  logic [2:0]                   lane_done;
  logic                         spd_done;
  logic [opsi_pkg::LVL_W-1:0]   spd_level;
  logic [opsi_pkg::IDX_W-1:0]   spd_n;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && in_data.cmd == opsi_pkg::CMD_LOAD;
  assign step_acc = in_acc && in_data.cmd == opsi_pkg::CMD_STEP;

  // step bookkeeping: the counter holds once the final point is reached
  assign cnt_inc = {1'b0, cnt_r} + 8'd1;
  assign tot_ext = {1'b0, total_r};
  always_comb begin
    if (cnt_inc < tot_ext) begin
      cnt_nxt   = cnt_inc[opsi_pkg::IDX_W-1:0];
      force_end = (cnt_inc + 8'd1) == tot_ext;
    end else begin
      cnt_nxt   = cnt_r;
      force_end = 1'b1;
    end
  end

  always_comb begin
    lane_ctl.load      = load_acc;
    lane_ctl.adv       = step_acc && !force_end;
    lane_ctl.force_end = step_acc && force_end;
    lane_ctl.div_start = state_r == ST_DIV_START;
  end

  assign div_den = spd_n - opsi_pkg::DEN_W'(1);

  // axis lanes
  opsi_lane u_lane_x (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .start_pos (in_data.start_x), .end_pos (in_data.end_x), .div_den (div_den),
    .abs_delta (abs_d[0]), .cur_pos (cur_p[0]), .nxt_pos (nxt_p[0]),
    .div_done (lane_done[0])
  );
  opsi_lane u_lane_y (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .start_pos (in_data.start_y), .end_pos (in_data.end_y), .div_den (div_den),
    .abs_delta (abs_d[1]), .cur_pos (cur_p[1]), .nxt_pos (nxt_p[1]),
    .div_done (lane_done[1])
  );
  opsi_lane u_lane_z (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .start_pos (in_data.start_z), .end_pos (in_data.end_z), .div_den (div_den),
    .abs_delta (abs_d[2]), .cur_pos (cur_p[2]), .nxt_pos (nxt_p[2]),
    .div_done (lane_done[2])
  );

  // merge: speed level and run length
  opsi_speed u_speed (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .load            (load_acc),
    .sub_block_count (in_data.sub_block_count),
    .start           (state_r == ST_SPD_START),
    .abs_x           (abs_d[0]),
    .abs_y           (abs_d[1]),
    .abs_z           (abs_d[2]),
    .done            (spd_done),
    .level           (spd_level),
    .run_length      (spd_n)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (load_acc) state_nxt = ST_SPD_START;
      ST_SPD_START: state_nxt = ST_SPD_WAIT;
      ST_SPD_WAIT:  if (spd_done) state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (lane_done[0]) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      total_r <= opsi_pkg::IDX_W'(2);
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_acc) cnt_r <= '0;
      else if (step_acc) cnt_r <= cnt_nxt;
      if (state_r == ST_DIV_START) begin
        total_r <= spd_n;
        level_r <= spd_level;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_rate     <= 8'd24;
      cfg_r.adaptive_speed <= 1'b0;
      cfg_r.thresh_one     <= opsi_pkg::POS_W'(839);
      cfg_r.thresh_two     <= opsi_pkg::POS_W'(1678);
      cfg_r.thresh_three   <= opsi_pkg::POS_W'(3355);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        opsi_pkg::CFG_FRAME_RATE: cfg_r.frame_rate <= cfg_wdata[opsi_pkg::FR_W-1:0];
        opsi_pkg::CFG_ADAPTIVE:   cfg_r.adaptive_speed <= cfg_wdata[0];
        opsi_pkg::CFG_THRESH_1:   cfg_r.thresh_one <= cfg_wdata;
        opsi_pkg::CFG_THRESH_2:   cfg_r.thresh_two <= cfg_wdata;
        opsi_pkg::CFG_THRESH_3:   cfg_r.thresh_three <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // output register: point 0 after a load, next point on a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_acc || (state_r == ST_EMIT && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_acc) begin
      out_data_r.pos_x       <= nxt_p[0];
      out_data_r.pos_y       <= nxt_p[1];
      out_data_r.pos_z       <= nxt_p[2];
      out_data_r.point_index <= cnt_nxt;
      out_data_r.run_length  <= total_r;
      out_data_r.speed_level <= level_r;
      out_data_r.last        <= ({1'b0, cnt_nxt} + 8'd1) == tot_ext;
    end else if (state_r == ST_EMIT && out_free) begin
      out_data_r.pos_x       <= cur_p[0];
      out_data_r.pos_y       <= cur_p[1];
      out_data_r.pos_z       <= cur_p[2];
      out_data_r.point_index <= '0;
      out_data_r.run_length  <= total_r;
      out_data_r.speed_level <= level_r;
      out_data_r.last        <= tot_ext == 8'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // counter never passes the final point of the run
  a_cnt_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < total_r)
    else $error("point counter beyond run length");

  // the three lane dividers run in lock step
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("lane dividers out of step");

  // a finished load posts point 0
  a_emit_point0: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free |=> out_valid_r && out_data_r.point_index == '0)
    else $error("load result not posted as point 0");

  // no transaction is taken while a load waits on a divider
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SPD_WAIT || state_r == ST_DIV_WAIT |-> !in_acc)
    else $error("transaction accepted during load");

endmodule

>>> design/opsi_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on opsi_pkg for widths.
module opsi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [opsi_pkg::DIV_W-1:0]  dividend,
  input  logic [opsi_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [opsi_pkg::DIV_W-1:0]  quotient
);

  localparam int CW = $clog2(opsi_pkg::DIV_W + 1);

  logic                        run_r;
  logic                        done_r;
  logic [CW-1:0]               count_r;
  logic [opsi_pkg::DEN_W-1:0]  rem_r;
  logic [opsi_pkg::DEN_W-1:0]  den_r;
  logic [opsi_pkg::DIV_W-1:0]  quo_r;
  logic [opsi_pkg::DEN_W:0]    trial;
  logic                        ge;

  assign trial = {rem_r, quo_r[opsi_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        count_r <= CW'(opsi_pkg::DIV_W);
      end else if (run_r) begin
        count_r <= count_r - CW'(1);
        if (count_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= ge ? opsi_pkg::DEN_W'(trial - {1'b0, den_r})
                  : trial[opsi_pkg::DEN_W-1:0];
      quo_r <= {quo_r[opsi_pkg::DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/opsi_lane.sv
// One axis lane: endpoints, |delta|, signed step offset and running position.
// Depends on opsi_pkg and opsi_div.
module opsi_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  opsi_pkg::lane_ctl_t          ctl,
  input  logic [opsi_pkg::POS_W-1:0]   start_pos,
  input  logic [opsi_pkg::POS_W-1:0]   end_pos,
  input  logic [opsi_pkg::DEN_W-1:0]   div_den,
  output logic [opsi_pkg::POS_W-1:0]   abs_delta,
  output logic [opsi_pkg::POS_W-1:0]   cur_pos,
  output logic [opsi_pkg::POS_W-1:0]   nxt_pos,
  output logic                         div_done
);

  logic [opsi_pkg::POS_W-1:0]         cur_r, end_r, abs_r;
  logic signed [opsi_pkg::STEP_W-1:0] step_r;
  logic                               neg_r;
  logic [opsi_pkg::DIV_W-1:0]         quo;
  logic [opsi_pkg::STEP_W-1:0]        q_ext;
  logic signed [opsi_pkg::STEP_W-1:0] sum;

  opsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend ({2'b00, abs_r}),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_ext   = quo[opsi_pkg::STEP_W-1:0];
  assign sum     = $signed({1'b0, cur_r}) + step_r;
  assign nxt_pos = ctl.force_end ? end_r : sum[opsi_pkg::POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      end_r  <= '0;
      step_r <= '0;
      abs_r  <= '0;
      neg_r  <= 1'b0;
    end else begin
      if (ctl.load) begin
        cur_r <= start_pos;
        end_r <= end_pos;
        neg_r <= end_pos < start_pos;
        abs_r <= (end_pos < start_pos) ? start_pos - end_pos : end_pos - start_pos;
      end else if (ctl.adv || ctl.force_end) begin
        cur_r <= nxt_pos;
      end
      if (div_done)
        step_r <= neg_r ? $signed(-q_ext) : $signed(q_ext);
    end
  end

  assign abs_delta = abs_r;
  assign cur_pos   = cur_r;

endmodule

>>> design/opsi_speed.sv
// Merging stage: sums lane |delta|, divides by sub-block count, classifies
// the speed level and looks up the run length. Depends on opsi_pkg, opsi_div.
module opsi_speed (
  input  logic                         clk,
  input  logic                         rst_n,
  input  opsi_pkg::cfg_t               cfg,
  input  logic                         load,
  input  logic [opsi_pkg::SBC_W-1:0]   sub_block_count,
  input  logic                         start,
  input  logic [opsi_pkg::POS_W-1:0]   abs_x,
  input  logic [opsi_pkg::POS_W-1:0]   abs_y,
  input  logic [opsi_pkg::POS_W-1:0]   abs_z,
  output logic                         done,
  output logic [opsi_pkg::LVL_W-1:0]   level,
  output logic [opsi_pkg::IDX_W-1:0]   run_length
);

  logic [opsi_pkg::DEN_W-1:0] cnt_r;
  logic [opsi_pkg::DEN_W-1:0] cnt_clamp;
  logic [opsi_pkg::DIV_W-1:0] sum;
  logic [opsi_pkg::DIV_W-1:0] speed;
  logic                       div_done;
  logic                       done_r;
  logic [opsi_pkg::LVL_W-1:0] lvl, level_r;
  logic [opsi_pkg::IDX_W-1:0] n_r;

  always_comb begin
    cnt_clamp = opsi_pkg::DEN_W'(sub_block_count);
    if (sub_block_count == '0) cnt_clamp = opsi_pkg::DEN_W'(1);
    else if (opsi_pkg::DEN_W'(sub_block_count) > opsi_pkg::DEN_W'(opsi_pkg::MAX_SUB_BLOCKS))
      cnt_clamp = opsi_pkg::DEN_W'(opsi_pkg::MAX_SUB_BLOCKS);
  end

  assign sum = opsi_pkg::DIV_W'(abs_x) + opsi_pkg::DIV_W'(abs_y) + opsi_pkg::DIV_W'(abs_z);

  opsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (sum),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (speed)
  );

  // thresholds tested in order, whether ascending or not
  always_comb begin
    priority if (!cfg.adaptive_speed)                               lvl = 2'd0;
    else if (speed < opsi_pkg::DIV_W'(cfg.thresh_one))              lvl = 2'd0;
    else if (speed < opsi_pkg::DIV_W'(cfg.thresh_two))              lvl = 2'd1;
    else if (speed < opsi_pkg::DIV_W'(cfg.thresh_three))            lvl = 2'd2;
    else                                                            lvl = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cnt_r <= cnt_clamp;
    if (div_done) begin
      level_r <= lvl;
      n_r     <= opsi_pkg::run_len(opsi_pkg::rate_row(cfg.frame_rate), lvl);
    end
  end

  assign done       = done_r;
  assign level      = level_r;
  assign run_length = n_r;

endmodule

>>> test/object_path_smoothing_interpolator_test.sv
// Self-checking bench for the object path smoothing interpolator: a directed table
// and randomized load/step runs, each result checked against a hand-written expectation or an in-bench predictor.
// Depends on opsi_pkg and the object_path_smoothing_interpolator RTL only.
module object_path_smoothing_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [opsi_pkg::POS_W-1:0] POS_MAX = {opsi_pkg::POS_W{1'b1}};
  localparam logic [opsi_pkg::POS_W-1:0] POS_ONE =
    opsi_pkg::POS_W'(1) << opsi_pkg::POS_FRAC_BITS;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 100;
  // The limit covers a whole load plus the longest sender gap and receiver
  // stall, with a wide margin.
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  opsi_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  opsi_pkg::out_item_t  out_data;
  logic                                 cfg_wr_en = 1'b0;
  logic [opsi_pkg::CFG_IDX_W-1:0]       cfg_index = opsi_pkg::CFG_FRAME_RATE;
  logic [opsi_pkg::POS_W-1:0]           cfg_wdata = '0;

  object_path_smoothing_interpolator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the run state.
  // ---------------------------------------------------------------------------
  logic [opsi_pkg::FR_W-1:0]          fps_reg;
  logic                               adaptive_reg;
  logic [opsi_pkg::POS_W-1:0]         speed_limit [3];
  logic signed [opsi_pkg::STEP_W-1:0] cur_pos [3];
  logic signed [opsi_pkg::STEP_W-1:0] step_off [3];
  logic [opsi_pkg::POS_W-1:0]         end_pos [3];
  int                                 pt_index;
  int                                 pt_total;
  int                                 lvl_held;

  opsi_pkg::out_item_t pending_points [$];   // expected points, oldest first
  int        mismatches = 0;
  int        calm_left = 0;        // transactions still to send back to back
  int        idle_cycles = 0;

  // Run length: row 0 gives 8/16/40/80 by level; the faster frame-rate rows
  // halve it once or twice.
  function automatic int points_per_run(logic [opsi_pkg::FR_W-1:0] fps, int lvl);
    int base;
    int shift;
    case (lvl)
      0: base = 8;
      1: base = 16;
      2: base = 40;
      default: base = 80;
    endcase
    case (fps)
      8'd48, 8'd50, 8'd60:   shift = 1;
      8'd96, 8'd100, 8'd120: shift = 2;
      default:               shift = 0;
    endcase
    return base >> shift;
  endfunction

  // Advances the predictor by one accepted transaction and returns the point
  // that the block has to emit for it.
  function automatic opsi_pkg::out_item_t next_path_point(opsi_pkg::in_item_t it);
    logic [opsi_pkg::POS_W-1:0] s [3];
    logic [opsi_pkg::POS_W-1:0] e [3];
    longint                     delta [3];
    longint                     motion;
    longint                     blocks;
    longint                     speed;
    int                         lvl;
    int                         n;
    opsi_pkg::out_item_t        p;
    s = '{it.start_x, it.start_y, it.start_z};
    e = '{it.end_x, it.end_y, it.end_z};
    if (it.cmd == opsi_pkg::CMD_LOAD) begin
      blocks = it.sub_block_count;
      if (blocks == 0) blocks = 1;
      if (blocks > opsi_pkg::MAX_SUB_BLOCKS) blocks = opsi_pkg::MAX_SUB_BLOCKS;
      motion = 0;
      for (int i = 0; i < 3; i++) begin
        delta[i] = longint'(e[i]) - longint'(s[i]);
        motion += (delta[i] < 0) ? -delta[i] : delta[i];
      end
      lvl = 0;
      if (adaptive_reg) begin
        // thresholds checked in order, ascending or not
        speed = motion / blocks;
        if (speed < longint'(speed_limit[0])) lvl = 0;
        else if (speed < longint'(speed_limit[1])) lvl = 1;
        else if (speed < longint'(speed_limit[2])) lvl = 2;
        else lvl = 3;
      end
      n = points_per_run(fps_reg, lvl);
      for (int i = 0; i < 3; i++) begin
        step_off[i] = opsi_pkg::STEP_W'(delta[i] / (n - 1));   // truncates toward zero
        cur_pos[i]  = opsi_pkg::STEP_W'(s[i]);
        end_pos[i]  = e[i];
      end
      pt_index = 0;
      pt_total = n;
      lvl_held = lvl;
    end else if (pt_index + 1 < pt_total) begin
      pt_index++;
      for (int i = 0; i < 3; i++) begin
        if (pt_index + 1 == pt_total) cur_pos[i] = opsi_pkg::STEP_W'(end_pos[i]);
        else cur_pos[i] = cur_pos[i] + step_off[i];
      end
    end else begin
      // past the end of the run: hold the counter, repeat the end point
      for (int i = 0; i < 3; i++) cur_pos[i] = opsi_pkg::STEP_W'(end_pos[i]);
    end
    p.pos_x       = cur_pos[0][opsi_pkg::POS_W-1:0];
    p.pos_y       = cur_pos[1][opsi_pkg::POS_W-1:0];
    p.pos_z       = cur_pos[2][opsi_pkg::POS_W-1:0];
    p.point_index = opsi_pkg::IDX_W'(pt_index);
    p.run_length  = opsi_pkg::IDX_W'(pt_total);
    p.speed_level = opsi_pkg::LVL_W'(lvl_held);
    p.last        = (pt_index + 1 == pt_total);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  typedef struct packed {
    opsi_pkg::in_item_t  item;
    logic                typed;   // want holds a hand-written expectation
    opsi_pkg::out_item_t want;
  } script_row_t;

  script_row_t script [$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Step transaction; the position fields are don't-care and carry noise.
  function automatic opsi_pkg::in_item_t step_item();
    opsi_pkg::in_item_t it;
    it.cmd             = opsi_pkg::CMD_STEP;
    it.start_x         = opsi_pkg::POS_W'($urandom);
    it.start_y         = opsi_pkg::POS_W'($urandom);
    it.start_z         = opsi_pkg::POS_W'($urandom);
    it.end_x           = opsi_pkg::POS_W'($urandom);
    it.end_y           = opsi_pkg::POS_W'($urandom);
    it.end_z           = opsi_pkg::POS_W'($urandom);
    it.sub_block_count = opsi_pkg::SBC_W'($urandom);
    return it;
  endfunction

  function automatic opsi_pkg::in_item_t load_item(
      logic [opsi_pkg::POS_W-1:0] sx, sy, sz, ex, ey, ez,
      logic [opsi_pkg::SBC_W-1:0] blocks);
    opsi_pkg::in_item_t it;
    it.cmd             = opsi_pkg::CMD_LOAD;
    it.start_x         = sx;
    it.start_y         = sy;
    it.start_z         = sz;
    it.end_x           = ex;
    it.end_y           = ey;
    it.end_z           = ez;
    it.sub_block_count = blocks;
    return it;
  endfunction

  function automatic opsi_pkg::out_item_t path_point(
      logic [opsi_pkg::POS_W-1:0] x, y, z, int idx, int run, int lvl, logic fin);
    opsi_pkg::out_item_t p;
    p.pos_x       = x;
    p.pos_y       = y;
    p.pos_z       = z;
    p.point_index = opsi_pkg::IDX_W'(idx);
    p.run_length  = opsi_pkg::IDX_W'(run);
    p.speed_level = opsi_pkg::LVL_W'(lvl);
    p.last        = fin;
    return p;
  endfunction

  function automatic void add_row(opsi_pkg::in_item_t it, logic typed,
                                  opsi_pkg::out_item_t want);
    script_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  function automatic logic [opsi_pkg::POS_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return POS_MAX;
    if (r == 2) return POS_ONE;
    return opsi_pkg::POS_W'($urandom_range(0, POS_MAX));
  endfunction

  // End point near the start at a log-random distance, so that every speed
  // level shows up; now and then an unrelated point.
  function automatic logic [opsi_pkg::POS_W-1:0] pick_end(
      logic [opsi_pkg::POS_W-1:0] from);
    longint span;
    longint target;
    if ($urandom_range(0, 7) == 0) return pick_coord();
    span = $urandom_range(0, POS_MAX) >> $urandom_range(0, 24);
    target = $urandom_range(0, 1) ? longint'(from) + span : longint'(from) - span;
    if (target < 0) target = 0;
    if (target > longint'(POS_MAX)) target = POS_MAX;
    return opsi_pkg::POS_W'(target);
  endfunction

  // Sends one transaction after a random gap, waits for the handshake, then
  // queues the expected point.
  task automatic drive_item(opsi_pkg::in_item_t it, logic typed,
                            opsi_pkg::out_item_t want);
    int                  gap;
    opsi_pkg::out_item_t predicted;
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (calm_left > 0) calm_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = next_path_point(it);
    pending_points.push_back(typed ? want : predicted);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s at %0t: got %0h, expected %0h", field, $time, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, mostly short, a few long, with stretches of
  // free flow in between, mostly short and now and then long.
  // ---------------------------------------------------------------------------
  initial begin
    int free_run;
    int hold;
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      hold = pick_gap();
      repeat (free_run) @(posedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every transaction leaving the block is matched against the
  // oldest expected point, field by field.
  // ---------------------------------------------------------------------------
  opsi_pkg::out_item_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point, index", out_data.point_index, 0);
      end else begin
        oldest = pending_points.pop_front();
        if (out_data.pos_x !== oldest.pos_x)
          report_mismatch("pos_x", out_data.pos_x, oldest.pos_x);
        if (out_data.pos_y !== oldest.pos_y)
          report_mismatch("pos_y", out_data.pos_y, oldest.pos_y);
        if (out_data.pos_z !== oldest.pos_z)
          report_mismatch("pos_z", out_data.pos_z, oldest.pos_z);
        if (out_data.point_index !== oldest.point_index)
          report_mismatch("point_index", out_data.point_index, oldest.point_index);
        if (out_data.run_length !== oldest.run_length)
          report_mismatch("run_length", out_data.run_length, oldest.run_length);
        if (out_data.speed_level !== oldest.speed_level)
          report_mismatch("speed_level", out_data.speed_level, oldest.speed_level);
        if (out_data.last !== oldest.last)
          report_mismatch("last", out_data.last, oldest.last);
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [opsi_pkg::CFG_IDX_W-1:0] cfg_regs [5];
    logic [opsi_pkg::POS_W-1:0]     cfg_vals [5];
    longint                         lim [3];
    int                             fps_list [9];
    int                             scale;
    int                             phase_items;
    int                             steps;
    int                             r;
    logic [opsi_pkg::POS_W-1:0]     sx, sy, sz;
    logic [opsi_pkg::SBC_W-1:0]     blocks;
    logic [opsi_pkg::FR_W-1:0]      fps;

    cfg_regs = '{opsi_pkg::CFG_FRAME_RATE, opsi_pkg::CFG_ADAPTIVE, opsi_pkg::CFG_THRESH_1,
                 opsi_pkg::CFG_THRESH_2, opsi_pkg::CFG_THRESH_3};
    fps_list = '{24, 25, 30, 48, 50, 60, 96, 100, 120};

    // predictor starts from the reset state
    fps_reg      = 8'd24;
    adaptive_reg = 1'b0;
    speed_limit  = '{opsi_pkg::POS_W'(839), opsi_pkg::POS_W'(1678),
                     opsi_pkg::POS_W'(3355)};
    for (int i = 0; i < 3; i++) begin
      cur_pos[i]  = '0;
      step_off[i] = '0;
      end_pos[i]  = '0;
    end
    pt_index = 0;
    pt_total = 2;
    lvl_held = 0;

    // Directed table, run with the reset settings (24 fps, fixed level 0,
    // so every loaded run is 8 points).
    // Step before any load: the reset run is two points at the origin.
    add_row(step_item(), 1'b1, path_point('0, '0, '0, 1, 2, 0, 1'b1));
    // Step past the end: the counter holds.
    add_row(step_item(), 1'b1, path_point('0, '0, '0, 1, 2, 0, 1'b1));
    // Origin to the far corner, zero sub-block count.
    add_row(load_item('0, '0, '0, POS_MAX, POS_MAX, POS_MAX, 5'd0), 1'b1,
            path_point('0, '0, '0, 0, 8, 0, 1'b0));
    repeat (6) add_row(step_item(), 1'b0, '0);
    add_row(step_item(), 1'b1, path_point(POS_MAX, POS_MAX, POS_MAX, 7, 8, 0, 1'b1));
    add_row(step_item(), 1'b1, path_point(POS_MAX, POS_MAX, POS_MAX, 7, 8, 0, 1'b1));
    // Back down, negative steps, sub-block count above the maximum.
    add_row(load_item(POS_MAX, POS_MAX, POS_MAX, '0, '0, '0, 5'd31), 1'b1,
            path_point(POS_MAX, POS_MAX, POS_MAX, 0, 8, 0, 1'b0));
    repeat (6) add_row(step_item(), 1'b0, '0);
    add_row(step_item(), 1'b1, path_point('0, '0, '0, 7, 8, 0, 1'b1));
    // No motion at all.
    add_row(load_item(25'h1555555, 25'h1555555, 25'h1555555,
                      25'h1555555, 25'h1555555, 25'h1555555, 5'd16), 1'b1,
            path_point(25'h1555555, 25'h1555555, 25'h1555555, 0, 8, 0, 1'b0));
    add_row(step_item(), 1'b0, '0);
    // Mixed directions around 1.0, a single sub-block.
    add_row(load_item(25'h0AAAAAA, POS_ONE, 25'h0000001,
                      25'h1555555, 25'h0FFFFFF, POS_ONE, 5'd1), 1'b1,
            path_point(25'h0AAAAAA, POS_ONE, 25'h0000001, 0, 8, 0, 1'b0));
    add_row(step_item(), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) drive_item(script[i].item, script[i].typed, script[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Settings change only with the block idle: every point received.
      in_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);

      if (phase == 0) begin
        // zero thresholds: every adaptive load lands on the top level
        fps = '0;
        cfg_vals[1] = {opsi_pkg::POS_W'($urandom)} | opsi_pkg::POS_W'(1);
        lim = '{0, 0, 0};
      end else if (phase == 1) begin
        fps = '1;
        cfg_vals[1] = {opsi_pkg::POS_W'($urandom)} | opsi_pkg::POS_W'(1);
        lim = '{POS_MAX, POS_MAX, POS_MAX};
      end else begin
        fps = ($urandom_range(0, 3) == 0) ? opsi_pkg::FR_W'($urandom)
                                          : opsi_pkg::FR_W'(fps_list[$urandom_range(0, 8)]);
        cfg_vals[1] = opsi_pkg::POS_W'($urandom);
        if ($urandom_range(0, 3) != 0) cfg_vals[1][0] = 1'b1;
        scale = $urandom_range(4, 22);
        lim[0] = $urandom_range(0, 1 << scale);
        lim[1] = lim[0] + $urandom_range(0, 1 << scale);
        lim[2] = lim[1] + $urandom_range(0, 2 << scale);
        // now and then thresholds out of order
        if ($urandom_range(0, 3) == 0)
          for (int i = 0; i < 3; i++) lim[i] = $urandom_range(0, POS_MAX) >> $urandom_range(0, 20);
      end
      // frame rate and mode registers carry noise above their used bits
      cfg_vals[0] = {opsi_pkg::POS_W'($urandom) << opsi_pkg::FR_W} | opsi_pkg::POS_W'(fps);
      for (int i = 0; i < 3; i++) cfg_vals[2 + i] = opsi_pkg::POS_W'(lim[i]);

      for (int i = 0; i < 5; i++) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= cfg_regs[i];
        cfg_wdata <= cfg_vals[i];
        @(posedge clk);
      end
      cfg_wr_en <= 1'b0;
      fps_reg      = cfg_vals[0][opsi_pkg::FR_W-1:0];
      adaptive_reg = cfg_vals[1][0];
      for (int i = 0; i < 3; i++) speed_limit[i] = cfg_vals[2 + i];

      // Mostly complete runs: a load and then steps up to the last point.
      // Some runs are cut short by the next load, some overrun the end.
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
        sx = pick_coord();
        sy = pick_coord();
        sz = pick_coord();
        blocks = ($urandom_range(0, 7) == 0) ? opsi_pkg::SBC_W'($urandom_range(0, 31))
                                             : opsi_pkg::SBC_W'($urandom_range(1, 16));
        drive_item(load_item(sx, sy, sz, pick_end(sx), pick_end(sy), pick_end(sz), blocks),
                   1'b0, '0);
        phase_items++;
        r = $urandom_range(0, 19);
        if (r < 14) steps = pt_total - 1;
        else if (r < 17) steps = $urandom_range(0, pt_total - 1);
        else steps = pt_total - 1 + $urandom_range(1, 3);
        repeat (steps) begin
          drive_item(step_item(), 1'b0, '0);
          phase_items++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    // watch for stray points after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
